@@ design/rfps_pkg.sv @@
package rfps_pkg;

	// field widths of one request and one result
	localparam int NUM_W = 16;
	localparam int STA_W = 8;
	localparam int POS_W = 5;

	// operation codes
	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_FIND = 2'd3
	} op_t;

	// one stored entry: status above number
	typedef struct packed {
		logic [STA_W-1:0] status;
		logic [NUM_W-1:0] number;
	} entry_t;

	// request payload
	typedef struct packed {
		op_t              operation;
		logic [NUM_W-1:0] token_number;
		logic [STA_W-1:0] token_status;
	} req_t;

	// result payload
	typedef struct packed {
		logic             ok;
		logic [NUM_W-1:0] out_number;
		logic [STA_W-1:0] out_status;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] fill_level;
		logic             is_empty;
		logic             is_full;
	} rsp_t;

endpackage

@@ design/rfps_chan_if.sv @@
interface rfps_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

@@ design/rfps_mem.sv @@
module rfps_mem #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  rfps_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output rfps_pkg::entry_t         rdata
);

	rfps_pkg::entry_t mem_q [DEPTH];
	rfps_pkg::entry_t rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/rfps_ctrl.sv @@
module rfps_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rfps_chan_if.sink                req,
	rfps_chan_if.source              rsp,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output rfps_pkg::entry_t         mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  rfps_pkg::entry_t         mem_rdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = (CNT_W > rfps_pkg::POS_W) ? CNT_W : rfps_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_PUSH
	} state_t;

	state_t                      state_q;
	logic [IDX_W-1:0]            head_q;
	logic [IDX_W-1:0]            tail_q;
	logic [CNT_W-1:0]            count_q;
	logic [rfps_pkg::NUM_W-1:0]  key_q;
	logic [IDX_W-1:0]            scan_idx_q;
	logic [CNT_W-1:0]            checked_q;
	logic                        ok_q;
	logic [rfps_pkg::NUM_W-1:0]  num_q;
	logic [rfps_pkg::STA_W-1:0]  sta_q;
	logic [rfps_pkg::POS_W-1:0]  pos_q;
	logic                        rsp_valid_q;
	rfps_pkg::rsp_t              rsp_data_q;

	logic             req_fire;
	logic             full;
	logic             empty;
	logic             slot_free;
	logic             match;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;

	// ring increment that wraps at the depth
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// count to the 5-bit result field, upper bits dropped
	function automatic logic [rfps_pkg::POS_W-1:0] to_field(input logic [CNT_W-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[rfps_pkg::POS_W-1:0];
	endfunction

	// handshake and status
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign head_next = next_slot(head_q);
	assign tail_next = next_slot(tail_q);

	// enqueue writes straight into the next tail slot
	assign mem_we           = req_fire && (req.data.operation == rfps_pkg::OP_ENQ) && !full;
	assign mem_waddr        = tail_next;
	assign mem_wdata.number = req.data.token_number;
	assign mem_wdata.status = req.data.token_status;

	// head read on acceptance, walking pointer while searching
	assign mem_raddr = (state_q == ST_SCAN) ? scan_idx_q : head_q;
	assign match     = (mem_rdata.number == key_q);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= IDX_W'(DEPTH - 1);
			count_q     <= '0;
			key_q       <= '0;
			scan_idx_q  <= '0;
			checked_q   <= '0;
			ok_q        <= 1'b0;
			num_q       <= '0;
			sta_q       <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// the push state loads the output register itself
			if (rsp_valid_q && rsp.ready && (state_q != ST_PUSH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						num_q <= '0;
						sta_q <= '0;
						pos_q <= '0;
						key_q <= req.data.token_number;
						case (req.data.operation) inside
							rfps_pkg::OP_ENQ: begin
								ok_q    <= !full;
								state_q <= ST_PUSH;
								if (!full) begin
									tail_q  <= tail_next;
									count_q <= count_q + 1'b1;
								end
							end
							rfps_pkg::OP_DEQ, rfps_pkg::OP_PEEK: begin
								ok_q <= 1'b0;
								if (!empty) begin
									if (req.data.operation == rfps_pkg::OP_DEQ) begin
										head_q  <= head_next;
										count_q <= count_q - 1'b1;
									end
									state_q <= ST_READ;
								end else begin
									state_q <= ST_PUSH;
								end
							end
							default: begin
								ok_q <= 1'b0;
								if (!empty) begin
									scan_idx_q <= head_next;
									checked_q  <= '0;
									state_q    <= ST_SCAN;
								end else begin
									state_q <= ST_PUSH;
								end
							end
						endcase
					end
				end
				ST_READ: begin
					ok_q    <= 1'b1;
					num_q   <= mem_rdata.number;
					sta_q   <= mem_rdata.status;
					state_q <= ST_PUSH;
				end
				ST_SCAN: begin
					// one entry compared per cycle, next read already issued
					scan_idx_q <= next_slot(scan_idx_q);
					if (match) begin
						ok_q    <= 1'b1;
						pos_q   <= to_field(checked_q + 1'b1);
						state_q <= ST_PUSH;
					end else if (checked_q + 1'b1 == count_q) begin
						state_q <= ST_PUSH;
					end else begin
						checked_q <= checked_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						rsp_valid_q           <= 1'b1;
						rsp_data_q.ok         <= ok_q;
						rsp_data_q.out_number <= num_q;
						rsp_data_q.out_status <= sta_q;
						rsp_data_q.position   <= pos_q;
						rsp_data_q.fill_level <= to_field(count_q);
						rsp_data_q.is_empty   <= empty;
						rsp_data_q.is_full    <= full;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/ring_fifo_with_position_search_unit.sv @@
// Circular queue of up to DEPTH entries (16-bit number, 8-bit status) held in one
// synchronous memory with a single write and a single registered read port. One
// request is handled at a time and each gives exactly one result. Enqueue goes
// from acceptance straight to the push state, dequeue and peek pass first through
// one memory read of the head, and a find walks from the head, comparing one
// stored entry per cycle through the single read port, until a hit or the last
// live entry. The push state waits while the previous result is not yet taken. A
// finished result sits in an output register, so a new request can be accepted
// while the previous result still waits to be taken. No clearing pass is needed
// after reset: only slots that hold live entries are ever read.
module ring_fifo_with_position_search_unit #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rfps_chan_if.sink   req,
	rfps_chan_if.source rsp
);

	localparam int IDX_W = $clog2(DEPTH);

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rfps_pkg::entry_t mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	rfps_pkg::entry_t mem_rdata;

	// sequencer with head, tail and count
	rfps_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// entry store
	rfps_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

@@ design/rfps_chk.sv @@
module rfps_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input rfps_pkg::rsp_t rsp_data
);

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// empty and full flags are never both set, and empty implies a zero fill level
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full)
			&& (!rsp_data.is_empty || rsp_data.fill_level == '0))
		else $error("inconsistent fill flags");

	// a failed request carries no entry and no position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.ok |-> rsp_data.out_number == '0
			&& rsp_data.out_status == '0 && rsp_data.position == '0)
		else $error("failed result with payload");

endmodule

bind ring_fifo_with_position_search_unit rfps_chk u_rfps_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

@@ test/tb_ring_fifo_with_position_search_unit.sv @@
`timescale 1ns / 1ps

module tb_ring_fifo_with_position_search_unit;

	localparam int QDEPTH = 16;
	localparam int RANDOM_ITEMS = 925;
	localparam int LONG_HOLD_CYCLES = 220;
	localparam int TAIL_CYCLES = 40;

	// operation mix of one random episode
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// queue predictor and store of expected results
	class queue_scoreboard;
		rfps_pkg::entry_t slots [QDEPTH];
		int unsigned      head_idx;
		int unsigned      tail_idx;
		int unsigned      held;
		rfps_pkg::rsp_t   expected_results [$];
		int unsigned      mismatches;

		function new();
			head_idx   = 0;
			tail_idx   = QDEPTH - 1;
			held       = 0;
			mismatches = 0;
		endfunction

		function int unsigned step_index(int unsigned i);
			return (i == QDEPTH - 1) ? 0 : i + 1;
		endfunction

		// number stored at a 0-based position counted from the head
		function logic [rfps_pkg::NUM_W-1:0] number_at(int unsigned k);
			return slots[(head_idx + k) % QDEPTH].number;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// apply one accepted request and queue the result it must give
		function void note_request(rfps_pkg::req_t r);
			rfps_pkg::rsp_t e;
			int unsigned    idx;
			e = '0;
			case (r.operation)
				rfps_pkg::OP_ENQ: begin
					if (held < QDEPTH) begin
						tail_idx = step_index(tail_idx);
						slots[tail_idx].number = r.token_number;
						slots[tail_idx].status = r.token_status;
						held++;
						e.ok = 1'b1;
					end
				end
				rfps_pkg::OP_DEQ, rfps_pkg::OP_PEEK: begin
					if (held != 0) begin
						e.ok         = 1'b1;
						e.out_number = slots[head_idx].number;
						e.out_status = slots[head_idx].status;
						if (r.operation == rfps_pkg::OP_DEQ) begin
							head_idx = step_index(head_idx);
							held--;
						end
					end
				end
				default: begin
					idx = head_idx;
					for (int unsigned i = 0; i < held; i++) begin
						if (slots[idx].number == r.token_number) begin
							e.ok       = 1'b1;
							e.position = rfps_pkg::POS_W'(i + 1);
							break;
						end
						idx = step_index(idx);
					end
				end
			endcase
			e.fill_level = rfps_pkg::POS_W'(held);
			e.is_empty   = (held == 0);
			e.is_full    = (held == QDEPTH);
			expected_results.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(rfps_pkg::rsp_t got);
			rfps_pkg::rsp_t e;
			if (expected_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
				return;
			end
			e = expected_results.pop_front();
			compare_field("ok", 32'(e.ok), 32'(got.ok));
			compare_field("out_number", 32'(e.out_number), 32'(got.out_number));
			compare_field("out_status", 32'(e.out_status), 32'(got.out_status));
			compare_field("position", 32'(e.position), 32'(got.position));
			compare_field("fill_level", 32'(e.fill_level), 32'(got.fill_level));
			compare_field("is_empty", 32'(e.is_empty), 32'(got.is_empty));
			compare_field("is_full", 32'(e.is_full), 32'(got.is_full));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   long_hold;

	queue_scoreboard board;

	rfps_chan_if #(.payload_t(rfps_pkg::req_t)) req_ch ();
	rfps_chan_if #(.payload_t(rfps_pkg::rsp_t)) rsp_ch ();

	ring_fifo_with_position_search_unit #(
		.DEPTH (QDEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_result(rsp_ch.data);
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				@(negedge clk) rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	// offer one request and wait for it to be taken
	task automatic send_request(rfps_pkg::op_t op, logic [rfps_pkg::NUM_W-1:0] num,
			logic [rfps_pkg::STA_W-1:0] sta);
		rfps_pkg::req_t r;
		r.operation    = op;
		r.token_number = num;
		r.token_status = sta;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk) req_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.note_request(r);
	endtask

	// withdraw the offer, then wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk) req_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic rfps_pkg::op_t pick_operation(mix_t mix);
		int unsigned w;
		w = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (w < 60) ? rfps_pkg::OP_ENQ : (w < 75) ? rfps_pkg::OP_DEQ :
				(w < 85) ? rfps_pkg::OP_PEEK : rfps_pkg::OP_FIND;
			MIX_DRAIN: return (w < 20) ? rfps_pkg::OP_ENQ : (w < 65) ? rfps_pkg::OP_DEQ :
				(w < 80) ? rfps_pkg::OP_PEEK : rfps_pkg::OP_FIND;
			default:   return (w < 35) ? rfps_pkg::OP_ENQ : (w < 60) ? rfps_pkg::OP_DEQ :
				(w < 75) ? rfps_pkg::OP_PEEK : rfps_pkg::OP_FIND;
		endcase
	endfunction

	// small pool half the time so that duplicates and hits are common
	function automatic logic [rfps_pkg::NUM_W-1:0] pick_number();
		if ($urandom_range(0, 1) == 0)
			return rfps_pkg::NUM_W'($urandom_range(0, 7));
		return rfps_pkg::NUM_W'($urandom_range(0, 65535));
	endfunction

	// request stream
	initial begin
		rfps_pkg::op_t              op;
		logic [rfps_pkg::NUM_W-1:0] num;
		mix_t                       mix;
		int                         episode_left;
		board         = new();
		quiet         = 1'b0;
		long_hold     = 1'b0;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty queue cases
		send_request(rfps_pkg::OP_PEEK, 16'h0000, 8'h00);
		send_request(rfps_pkg::OP_DEQ, 16'hFFFF, 8'hFF);
		send_request(rfps_pkg::OP_FIND, 16'h0000, 8'h00);
		// extremes of the entry fields, hits at both ends and a miss
		send_request(rfps_pkg::OP_ENQ, 16'h0000, 8'h00);
		send_request(rfps_pkg::OP_ENQ, 16'hFFFF, 8'hFF);
		send_request(rfps_pkg::OP_FIND, 16'hFFFF, 8'h00);
		send_request(rfps_pkg::OP_FIND, 16'h0000, 8'hFF);
		send_request(rfps_pkg::OP_FIND, 16'h1234, 8'h00);
		send_request(rfps_pkg::OP_PEEK, 16'h0000, 8'h00);
		// fill up, refused enqueue when full, hit at the last position
		for (int i = 0; i < 14; i++)
			send_request(rfps_pkg::OP_ENQ,
				(i == 13) ? 16'hA5A5 : rfps_pkg::NUM_W'(16'h0100 + i), 8'(8'h11 * i));
		send_request(rfps_pkg::OP_ENQ, 16'h5A5A, 8'h5A);
		send_request(rfps_pkg::OP_FIND, 16'hA5A5, 8'h00);

		// random episodes of fill, drain and balanced traffic
		mix          = MIX_EVEN;
		episode_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				long_hold = 1'b1;
			if (n == 600)
				wait_drained();
			if (n == RANDOM_ITEMS - 150)
				quiet = 1'b1;
			if (episode_left == 0) begin
				mix          = mix_t'($urandom_range(0, 2));
				episode_left = $urandom_range(10, 40);
			end
			episode_left--;
			op = pick_operation(mix);
			if (op == rfps_pkg::OP_FIND && board.held != 0 && $urandom_range(0, 9) < 7)
				num = board.number_at($urandom_range(0, board.held - 1));
			else
				num = pick_number();
			send_request(op, num, rfps_pkg::STA_W'($urandom_range(0, 255)));
		end
		@(negedge clk) req_ch.valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
